/* rtl/core/assert_macros.svh */
// Assertion shorthands shared by the checker files.
// Both sample on the rising edge of clk and stay quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/mpid_pkg.sv */
package mpid_pkg;

  // Channel count and number formats
  localparam int CHANNELS      = 4;
  localparam int GAIN_BITS     = 16;
  localparam int INTEGRAL_BITS = 40;

  localparam int LANES         = 4;
  localparam int LANE_BITS     = 16;
  localparam int LANE_IDX_BITS = 2;
  localparam int GAIN_REG_BITS = LANES * LANE_BITS;
  localparam int SAMPLE_BITS   = 16;
  localparam int ERR_BITS      = SAMPLE_BITS + 1;
  localparam int DIFF_BITS     = ERR_BITS + 1;
  localparam int TIME_BITS     = 16;
  localparam int ACT_BITS      = 3;
  localparam int DRIVE_BITS    = 32;
  localparam int CH_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration port
  localparam int DATA_BITS     = 64;
  localparam int ADDR_BITS     = 6;
  localparam int REG_LSB       = 3;

  // Shared multiplier operands and product
  localparam int MUL_A_BITS    = 18;
  localparam int MUL_B_BITS    = 25;
  localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;

  // Integral split into two multiplier passes
  localparam int ILO_BITS      = INTEGRAL_BITS / 2;
  localparam int ISUM_BITS     = ((INTEGRAL_BITS > 34) ? INTEGRAL_BITS : 34) + 1;

  // Derivative product Kd*(e - e_prev), split before scaling by 1/Ts
  localparam int KDD_BITS      = GAIN_BITS + DIFF_BITS;
  localparam int KDD_LO_BITS   = 24;
  localparam int KDD_HI_BITS   = KDD_BITS - KDD_LO_BITS;

  // Channel total with 16 fraction bits, room for all channels summed
  localparam int TOT_BITS      = GAIN_BITS + ((INTEGRAL_BITS > 35) ? INTEGRAL_BITS : 35) + 3;
  localparam int FRAC_BITS     = 16;
  localparam int KP_SHIFT      = 8;

  typedef struct packed {
    logic [GAIN_REG_BITS-1:0] kp;
    logic [GAIN_REG_BITS-1:0] ki;
    logic [GAIN_REG_BITS-1:0] kd;
    logic [TIME_BITS-1:0]     st;
    logic [TIME_BITS-1:0]     ist;
    logic                     sum_mode;
    logic [ACT_BITS-1:0]      act;
  } cfg_t;

  typedef struct packed {
    logic                          valid;
    logic [LANES*DRIVE_BITS-1:0]   drives;
  } res_t;

endpackage

/* rtl/core/multichannel_pid_controller_top.sv */
// Step transaction: for each active channel, load, seven products on the single shared
// 18x25 multiplier, then accumulate and round. Init transaction: load each active channel's
// last error only. A new transaction is taken only while the sequencer is idle, after the
// previous result has left it.
// The result waits in an output register, so the next input is taken while it is pending.
// Synchronous active-high reset: registers to defaults, integrals and last errors to zero.
module multichannel_pid_controller_top (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // meas_0, meas_1, meas_2, meas_3, ref_0, ref_1, ref_2, ref_3 (16 bits each, lowest first)
  input  logic [2*mpid_pkg::LANES*mpid_pkg::SAMPLE_BITS-1:0] s_axis_tdata,
  // func
  input  logic                                          s_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // drive_0, drive_1, drive_2, drive_3 (32 bits each, lowest first)
  output logic [mpid_pkg::LANES*mpid_pkg::DRIVE_BITS-1:0] m_axis_tdata,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [mpid_pkg::ADDR_BITS-1:0]                paddr,
  input  logic [mpid_pkg::DATA_BITS-1:0]                pwdata,
  output logic [mpid_pkg::DATA_BITS-1:0]                prdata,
  output logic                                          pready
);
  import mpid_pkg::*;

  localparam int SAMPLES_BITS = LANES * SAMPLE_BITS;

  cfg_t cfg;
  res_t res;
  logic take;
  logic start;

  mpid_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign start = s_axis_tvalid && s_axis_tready;
  assign take  = !m_axis_tvalid || m_axis_tready;

  mpid_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .start   (start),
    .func_in (s_axis_tuser),
    .meas_in (s_axis_tdata[SAMPLES_BITS-1:0]),
    .ref_in  (s_axis_tdata[2*SAMPLES_BITS-1:SAMPLES_BITS]),
    .take    (take),
    .ready   (s_axis_tready),
    .res     (res)
  );

  // Output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.valid && take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && take) begin
      m_axis_tdata <= res.drives;
    end
  end

endmodule

/* rtl/core/mpid_mul.sv */
module mpid_mul (
  input  logic                                  clk,
  input  logic signed [mpid_pkg::MUL_A_BITS-1:0] a,
  input  logic signed [mpid_pkg::MUL_B_BITS-1:0] b,
  output logic signed [mpid_pkg::PROD_BITS-1:0]  prod
);
  import mpid_pkg::*;

  // Register every product so the consumer sees it in the cycle after its operands
  always_ff @(posedge clk) begin
    prod <= PROD_BITS'(a) * PROD_BITS'(b);
  end

endmodule

/* rtl/core/mpid_cfg.sv */
module mpid_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpid_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mpid_pkg::DATA_BITS-1:0] pwdata,
  output logic [mpid_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  output mpid_pkg::cfg_t                 cfg
);
  import mpid_pkg::*;

  localparam logic [2:0] REG_KP  = 3'd0;
  localparam logic [2:0] REG_KI  = 3'd1;
  localparam logic [2:0] REG_KD  = 3'd2;
  localparam logic [2:0] REG_ST  = 3'd3;
  localparam logic [2:0] REG_IST = 3'd4;
  localparam logic [2:0] REG_SUM = 3'd5;
  localparam logic [2:0] REG_ACT = 3'd6;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_BITS-1:REG_LSB];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp       <= '0;
      cfg.ki       <= '0;
      cfg.kd       <= '0;
      cfg.st       <= TIME_BITS'(256);
      cfg.ist      <= TIME_BITS'(256);
      cfg.sum_mode <= 1'b0;
      cfg.act      <= ACT_BITS'(4);
    end else if (wr_en) begin
      case (reg_idx)
        REG_KP:  cfg.kp       <= pwdata[GAIN_REG_BITS-1:0];
        REG_KI:  cfg.ki       <= pwdata[GAIN_REG_BITS-1:0];
        REG_KD:  cfg.kd       <= pwdata[GAIN_REG_BITS-1:0];
        REG_ST:  cfg.st       <= pwdata[TIME_BITS-1:0];
        REG_IST: cfg.ist      <= pwdata[TIME_BITS-1:0];
        REG_SUM: cfg.sum_mode <= pwdata[0];
        REG_ACT: cfg.act      <= pwdata[ACT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_KP:  prdata = DATA_BITS'(cfg.kp);
      REG_KI:  prdata = DATA_BITS'(cfg.ki);
      REG_KD:  prdata = DATA_BITS'(cfg.kd);
      REG_ST:  prdata = DATA_BITS'(cfg.st);
      REG_IST: prdata = DATA_BITS'(cfg.ist);
      REG_SUM: prdata = DATA_BITS'(cfg.sum_mode);
      REG_ACT: prdata = DATA_BITS'(cfg.act);
      default: prdata = '0;
    endcase
  end

endmodule

/* rtl/core/mpid_core.sv */
module mpid_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mpid_pkg::cfg_t                       cfg,
  input  logic                                 start,
  input  logic                                 func_in,
  input  logic [mpid_pkg::LANES*mpid_pkg::SAMPLE_BITS-1:0] meas_in,
  input  logic [mpid_pkg::LANES*mpid_pkg::SAMPLE_BITS-1:0] ref_in,
  input  logic                                 take,
  output logic                                 ready,
  output mpid_pkg::res_t                       res
);
  import mpid_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL_ST, S_MUL_KP, S_MUL_KILO, S_MUL_KIHI,
    S_MUL_KD, S_MUL_DLO, S_MUL_DHI, S_ACC_LAST, S_FINISH, S_DONE
  } state_t;

  localparam logic signed [ISUM_BITS-1:0] IMAX =
    ISUM_BITS'((64'sd1 <<< (INTEGRAL_BITS - 1)) - 64'sd1);
  localparam logic signed [ISUM_BITS-1:0] IMIN = -IMAX - ISUM_BITS'(1);
  localparam logic signed [TOT_BITS-1:0] HALF = TOT_BITS'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [TOT_BITS-1:0] DMAX = TOT_BITS'(64'sh7FFF_FFFF);
  localparam logic signed [TOT_BITS-1:0] DMIN = -DMAX - TOT_BITS'(1);

  state_t                            state;
  logic [CH_BITS-1:0]                ch;
  logic                              func_r;
  logic signed [SAMPLE_BITS-1:0]     meas_r [CHANNELS];
  logic signed [SAMPLE_BITS-1:0]     ref_r  [CHANNELS];
  logic signed [INTEGRAL_BITS-1:0]   integ  [CHANNELS];
  logic signed [ERR_BITS-1:0]        prev   [CHANNELS];
  logic signed [ERR_BITS-1:0]        e_r;
  logic signed [DIFF_BITS-1:0]       d_r;
  logic signed [INTEGRAL_BITS-1:0]   acc_r;
  logic signed [KDD_HI_BITS-1:0]     kdd_hi;
  logic signed [TOT_BITS-1:0]        tot;
  logic [DRIVE_BITS-1:0]             drive  [LANES];

  logic signed [ERR_BITS-1:0]        e_now;
  logic signed [DIFF_BITS-1:0]       d_now;
  logic signed [GAIN_BITS-1:0]       kp_g, ki_g, kd_g;
  logic signed [ISUM_BITS-1:0]       isum;
  logic signed [INTEGRAL_BITS-1:0]   isat;
  logic [ACT_BITS-1:0]               eff_act;
  logic                              last_ch;
  logic signed [MUL_A_BITS-1:0]      mul_a;
  logic signed [MUL_B_BITS-1:0]      mul_b;
  logic signed [PROD_BITS-1:0]       prod;

  // Round half up to an integer, then clamp to the drive range
  function automatic logic [DRIVE_BITS-1:0] round_sat(input logic signed [TOT_BITS-1:0] t);
    logic signed [TOT_BITS-1:0] r;
    r = (t + HALF) >>> FRAC_BITS;
    if (r > DMAX) begin
      return {1'b0, {(DRIVE_BITS-1){1'b1}}};
    end else if (r < DMIN) begin
      return {1'b1, {(DRIVE_BITS-1){1'b0}}};
    end else begin
      return r[DRIVE_BITS-1:0];
    end
  endfunction

  // Clamp the active count to 1..CHANNELS
  always_comb begin
    if (cfg.act == '0) begin
      eff_act = ACT_BITS'(1);
    end else if (cfg.act > ACT_BITS'(CHANNELS)) begin
      eff_act = ACT_BITS'(CHANNELS);
    end else begin
      eff_act = cfg.act;
    end
  end

  assign last_ch = (ch == CH_BITS'(eff_act - ACT_BITS'(1)));

  // Per-channel operands
  assign e_now = ERR_BITS'(ref_r[ch]) - ERR_BITS'(meas_r[ch]);
  assign d_now = DIFF_BITS'(e_now) - DIFF_BITS'(prev[ch]);
  assign kp_g  = $signed(cfg.kp[int'(ch)*LANE_BITS +: GAIN_BITS]);
  assign ki_g  = $signed(cfg.ki[int'(ch)*LANE_BITS +: GAIN_BITS]);
  assign kd_g  = $signed(cfg.kd[int'(ch)*LANE_BITS +: GAIN_BITS]);

  // Integral update from the registered e*Ts product, saturated
  always_comb begin
    isum = ISUM_BITS'(integ[ch]) + ISUM_BITS'(prod);
    if (isum > IMAX) begin
      isat = INTEGRAL_BITS'(IMAX);
    end else if (isum < IMIN) begin
      isat = INTEGRAL_BITS'(IMIN);
    end else begin
      isat = INTEGRAL_BITS'(isum);
    end
  end

  // Select multiplier operands for the current step
  always_comb begin
    case (state)
      S_MUL_ST: begin
        mul_a = MUL_A_BITS'({1'b0, cfg.st});
        mul_b = MUL_B_BITS'(e_r);
      end
      S_MUL_KP: begin
        mul_a = MUL_A_BITS'(kp_g);
        mul_b = MUL_B_BITS'(e_r);
      end
      S_MUL_KILO: begin
        mul_a = MUL_A_BITS'(ki_g);
        mul_b = MUL_B_BITS'(acc_r[ILO_BITS-1:0]);
      end
      S_MUL_KIHI: begin
        mul_a = MUL_A_BITS'(ki_g);
        mul_b = MUL_B_BITS'($signed(acc_r[INTEGRAL_BITS-1:ILO_BITS]));
      end
      S_MUL_KD: begin
        mul_a = MUL_A_BITS'(kd_g);
        mul_b = MUL_B_BITS'(d_r);
      end
      S_MUL_DLO: begin
        mul_a = MUL_A_BITS'({1'b0, cfg.ist});
        mul_b = MUL_B_BITS'(prod[KDD_LO_BITS-1:0]);
      end
      S_MUL_DHI: begin
        mul_a = MUL_A_BITS'({1'b0, cfg.ist});
        mul_b = MUL_B_BITS'(kdd_hi);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mpid_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Sequencer: walk the active channels, one shared multiply per cycle in the multiply states
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        integ[c] <= '0;
        prev[c]  <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            func_r <= func_in;
            for (int c = 0; c < CHANNELS; c++) begin
              meas_r[c] <= $signed(meas_in[c*SAMPLE_BITS +: SAMPLE_BITS]);
              ref_r[c]  <= $signed(ref_in[c*SAMPLE_BITS +: SAMPLE_BITS]);
            end
            for (int c = 0; c < LANES; c++) begin
              drive[c] <= '0;
            end
            ch    <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (func_r) begin
            // Init transaction: only load the last error
            prev[ch] <= e_now;
            if (last_ch) begin
              state <= S_DONE;
            end else begin
              ch    <= ch + CH_BITS'(1);
              state <= S_LOAD;
            end
          end else begin
            e_r <= e_now;
            d_r <= d_now;
            if (!cfg.sum_mode || ch == '0) begin
              tot <= '0;
            end
            state <= S_MUL_ST;
          end
        end
        S_MUL_ST: begin
          state <= S_MUL_KP;
        end
        S_MUL_KP: begin
          integ[ch] <= isat;
          acc_r     <= isat;
          state     <= S_MUL_KILO;
        end
        S_MUL_KILO: begin
          tot   <= tot + (TOT_BITS'(prod) <<< KP_SHIFT);
          state <= S_MUL_KIHI;
        end
        S_MUL_KIHI: begin
          tot   <= tot + TOT_BITS'(prod);
          state <= S_MUL_KD;
        end
        S_MUL_KD: begin
          tot   <= tot + (TOT_BITS'(prod) <<< ILO_BITS);
          state <= S_MUL_DLO;
        end
        S_MUL_DLO: begin
          kdd_hi <= $signed(prod[KDD_BITS-1:KDD_LO_BITS]);
          state  <= S_MUL_DHI;
        end
        S_MUL_DHI: begin
          tot   <= tot + TOT_BITS'(prod);
          state <= S_ACC_LAST;
        end
        S_ACC_LAST: begin
          tot      <= tot + (TOT_BITS'(prod) <<< KDD_LO_BITS);
          prev[ch] <= e_r;
          state    <= S_FINISH;
        end
        S_FINISH: begin
          if (!cfg.sum_mode) begin
            drive[LANE_IDX_BITS'(ch)] <= round_sat(tot);
          end else if (last_ch) begin
            drive[0] <= round_sat(tot);
          end
          if (last_ch) begin
            state <= S_DONE;
          end else begin
            ch    <= ch + CH_BITS'(1);
            state <= S_LOAD;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Handshake and result
  assign ready     = (state == S_IDLE);
  assign res.valid = (state == S_DONE);

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      res.drives[c*DRIVE_BITS +: DRIVE_BITS] = drive[c];
    end
  end

endmodule

/* rtl/core/mpid_checker.sv */
`include "assert_macros.svh"

module mpid_checker (
  input logic                                              clk,
  input logic                                              rst,
  input logic                                              s_axis_tvalid,
  input logic                                              s_axis_tready,
  input logic [2*mpid_pkg::LANES*mpid_pkg::SAMPLE_BITS-1:0] s_axis_tdata,
  input logic                                              s_axis_tuser,
  input logic                                              m_axis_tvalid,
  input logic                                              m_axis_tready,
  input logic [mpid_pkg::LANES*mpid_pkg::DRIVE_BITS-1:0]   m_axis_tdata,
  input logic                                              psel,
  input logic                                              penable,
  input logic                                              pwrite,
  input logic [mpid_pkg::ADDR_BITS-1:0]                    paddr,
  input logic [mpid_pkg::DATA_BITS-1:0]                    pwdata,
  input logic [mpid_pkg::DATA_BITS-1:0]                    prdata,
  input logic                                              pready
);

  // One transaction at a time: input side closes right after an accept
  `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A result never appears in the cycle right after an accept into an empty output
  `ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid)

  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Register port never waits
  `ASSERT_IMPL(a_pready_high, psel, pready)

endmodule

bind multichannel_pid_controller_top mpid_checker u_mpid_checker (.*);
